// ===== sv/w3f_pkg.sv =====
// Shared types, codes and helper functions for the 3x3 window filter engine.
package w3f_pkg;

  localparam int W3F_MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [11:0] WIDTH_RESET = 12'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // floor(x * RECIP9 / 2^15) equals floor(x / 9) for every 3x3 sum of bytes.
  localparam logic [22:0] RECIP9 = 23'd3641;

  typedef enum logic [2:0] {
    MODE_AVG     = 3'd0,
    MODE_MEDIAN  = 3'd1,
    MODE_ROBERTS = 3'd2,
    MODE_PREWITT = 3'd3,
    MODE_SOBEL   = 3'd4,
    MODE_SHARPEN = 3'd5
  } mode_t;

  // Control carried with an item from the input counters to the window stage.
  typedef struct packed {
    logic shift;    // shift a new column into the window
    logic from_px;  // bottom row comes from the pixel, and the line stores are written
    logic top_up;   // top row comes from the upper store, else from the middle store
    logic post;     // the result is taken after the shift
    logic c1;       // the item sits in column one, so the left column replicates
    logic emit;     // the item produces a result
    logic last;     // the result closes the frame
  } ctl_t;

  function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic [7:0] lo, hi, md;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) begin
      md = lo;
      lo = c;
    end else if (c > hi) begin
      md = hi;
      hi = c;
    end else begin
      md = c;
    end
    return {hi, md, lo};
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [23:0] s;
    s = sort3(a, b, c);
    return s[15:8];
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [10:0] absd(input logic [10:0] a, input logic [10:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Clamp a two's complement value to 0..255.
  function automatic logic [7:0] sat8(input logic [12:0] v);
    if (v[12]) begin
      return 8'd0;
    end else if (v[11:8] != 4'd0) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

// ===== sv/w3f_pix_in_if.sv =====
// Input channel of the window filter engine: pixel or flush items.
interface w3f_pix_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source(output valid, command, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink(input valid, command, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// ===== sv/w3f_pix_out_if.sv =====
// Output channel of the window filter engine: filtered pixels.
interface w3f_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       frame_last;

  modport source(output valid, red_out, green_out, blue_out, alpha_out, frame_last,
                 input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out, frame_last,
               output ready);
endinterface

// ===== sv/w3f_line_window.sv =====
// Line stores, 3x3 window registers and the neighborhood snapshot register.
module w3f_line_window
  import w3f_pkg::*;
#(
  parameter int MAX_WIDTH = W3F_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          go,
  input  ctl_t          ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   px,
  output logic [31:0]   snap [9]
);

  logic [31:0] upper [MAX_WIDTH];
  logic [31:0] middle [MAX_WIDTH];
  logic [31:0] up_q;
  logic [31:0] mid_q;
  logic [31:0] win [3][3];
  logic [31:0] newcol [3];

  // Consecutive items always address different columns, so a read never
  // meets a write to the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q  <= upper[rd_addr];
      mid_q <= middle[rd_addr];
    end
    if (go && ctl.from_px) begin
      upper[wr_addr]  <= mid_q;
      middle[wr_addr] <= px;
    end
  end

  always_comb begin
    newcol[0] = ctl.top_up ? up_q : mid_q;
    newcol[1] = mid_q;
    newcol[2] = ctl.from_px ? px : mid_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int row = 0; row < 3; row++) begin
        for (int col = 0; col < 3; col++) begin
          win[row][col] <= '0;
        end
      end
    end else if (go && ctl.shift) begin
      for (int row = 0; row < 3; row++) begin
        win[row][0] <= win[row][1];
        win[row][1] <= win[row][2];
        win[row][2] <= newcol[row];
      end
    end
  end

  // A result after the shift sees the window as old columns one and two plus
  // the new column; otherwise the right border replicates the current column.
  always_ff @(posedge clk) begin
    if (go) begin
      for (int row = 0; row < 3; row++) begin
        snap[row*3]   <= (ctl.post && ctl.c1) ? win[row][2] : win[row][1];
        snap[row*3+1] <= win[row][2];
        snap[row*3+2] <= ctl.post ? newcol[row] : win[row][2];
      end
    end
  end

endmodule

// ===== sv/w3f_chan_filter.sv =====
// Two-stage filter datapath for one color channel of the 3x3 neighborhood.
module w3f_chan_filter
  import w3f_pkg::*;
(
  input  logic       clk,
  input  logic       ld_a,
  input  logic       ld_b,
  input  logic [2:0] mode,
  input  logic [7:0] a [9],
  output logic [7:0] res
);

  logic [11:0] sum;
  logic [11:0] sum_q;
  logic [23:0] rows [3];
  logic [23:0] rows_q [3];
  logic [12:0] edge_v;
  logic [12:0] edge_q;
  logic [10:0] t, b, l, r;
  logic [11:0] ten;
  logic [22:0] prod;
  logic [7:0]  res_next;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      sum = sum + 12'(a[i]);
    end
    for (int i = 0; i < 3; i++) begin
      rows[i] = sort3(a[i*3], a[i*3+1], a[i*3+2]);
    end
    t = 11'(a[0]) + 11'(a[2]);
    b = 11'(a[6]) + 11'(a[8]);
    r = 11'(a[2]) + 11'(a[8]);
    l = 11'(a[0]) + 11'(a[6]);
    ten = {1'b0, a[4], 3'b000} + {3'b000, a[4], 1'b0};
    case (mode_t'(mode))
      MODE_ROBERTS: begin
        edge_v = 13'(absd(11'(a[4]), 11'(a[2]))) + 13'(absd(11'(a[5]), 11'(a[1])));
      end
      MODE_PREWITT: begin
        edge_v = 13'(absd(t + 11'(a[1]), b + 11'(a[7])))
               + 13'(absd(r + 11'(a[5]), l + 11'(a[3])));
      end
      MODE_SOBEL: begin
        edge_v = 13'(absd(t + {2'b00, a[1], 1'b0}, b + {2'b00, a[7], 1'b0}))
               + 13'(absd(r + {2'b00, a[5], 1'b0}, l + {2'b00, a[3], 1'b0}));
      end
      MODE_SHARPEN: begin
        edge_v = 13'(ten) - 13'(sum);
      end
      default: begin
        edge_v = 13'(a[4]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      sum_q  <= sum;
      rows_q <= rows;
      edge_q <= edge_v;
    end
  end

  // Median of nine: the median of the largest row minimum, the median row
  // median and the smallest row maximum.
  always_comb begin
    prod = 23'(sum_q) * RECIP9;
    case (mode_t'(mode))
      MODE_AVG: res_next = prod[22:15];
      MODE_MEDIAN: begin
        res_next = med3(max3(rows_q[0][7:0], rows_q[1][7:0], rows_q[2][7:0]),
                        med3(rows_q[0][15:8], rows_q[1][15:8], rows_q[2][15:8]),
                        min3(rows_q[0][23:16], rows_q[1][23:16], rows_q[2][23:16]));
      end
      MODE_ROBERTS, MODE_PREWITT, MODE_SOBEL, MODE_SHARPEN: res_next = sat8(edge_q);
      default: res_next = edge_q[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      res <= res_next;
    end
  end

endmodule

// ===== sv/window_3x3_filter_engine.sv =====
// Top level of the 3x3 window filter engine: counters, pipeline control and datapath.
//
//   channel   direction  handshake       payload
//   pix_in    sink       valid / ready   command, red_in, green_in, blue_in, alpha_in
//   pix_out   source     valid / ready   red_out, green_out, blue_out, alpha_out, frame_last
//   cfg       write      cfg_en          cfg_index, cfg_data
//
// One item is taken every cycle unless a blocked output fills the stages; a result leaves
// after its item passes the line store read, the window stage and two filter stages.
// The result for a center pixel is caused by the item one row plus one pixel later.
// Each stage holds only while it is full and the stage after it is blocked, so
// bubbles are squeezed out and input is taken while a result waits at the output.
// Reset is synchronous and needs no clearing pass; the line stores start undefined.
module window_3x3_filter_engine
  import w3f_pkg::*;
#(
  parameter int MAX_WIDTH = W3F_MAX_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_en,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  w3f_pix_in_if.sink         pix_in,
  w3f_pix_out_if.source      pix_out
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [2:0]    filter_mode;
  logic [11:0]   image_width;
  logic [12:0]   image_height;
  logic [CW-1:0] eff_w;
  logic [12:0]   eff_h;

  logic          draining, drain_next;
  logic [CW-1:0] col, col_next, col_inc;
  logic [11:0]   row, row_next;
  logic [12:0]   row_inc;
  logic          act;
  ctl_t          ctl_next;

  logic          accept, en1, en2, en3, en4, go;
  logic          v1, v2, v3, out_v;
  ctl_t          ctl1;
  logic [AW-1:0] addr1;
  logic [31:0]   px1;
  logic          last2, last3;
  logic [7:0]    alpha3;
  logic [31:0]   snap [9];
  logic [7:0]    chan_px [3][9];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= '0;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_MODE: filter_mode <= cfg_data[2:0];
        REG_WIDTH: image_width <= cfg_data[11:0];
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < 12'd2) begin
      eff_w = CW'(2);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(image_width);
    end
    if (image_height < 13'd2) begin
      eff_h = 13'd2;
    end else if (image_height > 13'(MAX_HEIGHT)) begin
      eff_h = 13'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  // Decide what an item does from the raster position, and advance it.
  always_comb begin
    ctl_next   = '0;
    act        = 1'b0;
    col_next   = col;
    row_next   = row;
    drain_next = draining;
    col_inc    = col + 1'b1;
    row_inc    = {1'b0, row} + 13'd1;
    if (!draining) begin
      if (pix_in.command == CMD_PIXEL) begin
        act              = 1'b1;
        ctl_next.shift   = 1'b1;
        ctl_next.from_px = 1'b1;
        ctl_next.top_up  = row >= 12'd2;
        ctl_next.post    = col != '0 && row != '0;
        ctl_next.c1      = col == CW'(1);
        ctl_next.emit    = (col == '0 && row >= 12'd2) || ctl_next.post;
        if (col_inc >= eff_w) begin
          col_next = '0;
          if (row_inc >= eff_h) begin
            row_next   = '0;
            drain_next = 1'b1;
          end else begin
            row_next = row_inc[11:0];
          end
        end else begin
          col_next = col_inc;
        end
      end
    end else if (col >= eff_w) begin
      act           = 1'b1;
      ctl_next.emit = 1'b1;
      ctl_next.last = 1'b1;
      col_next      = '0;
      row_next      = '0;
      drain_next    = 1'b0;
    end else begin
      // Past the bottom row the last line replicates downward.
      act             = 1'b1;
      ctl_next.shift  = 1'b1;
      ctl_next.top_up = 1'b1;
      ctl_next.post   = col != '0;
      ctl_next.c1     = col == CW'(1);
      ctl_next.emit   = 1'b1;
      col_next        = col_inc;
    end
  end

  assign en4 = !out_v || pix_out.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign go = v1 && en2;
  assign pix_in.ready = en1;
  assign accept = pix_in.valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      col      <= '0;
      row      <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      out_v    <= 1'b0;
    end else begin
      if (accept) begin
        draining <= drain_next;
        col      <= col_next;
        row      <= row_next;
      end
      if (en1) begin
        v1 <= accept && act;
      end
      if (en2) begin
        v2 <= v1 && ctl1.emit;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        out_v <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl1  <= ctl_next;
      addr1 <= col[AW-1:0];
      px1   <= {pix_in.alpha_in, pix_in.blue_in, pix_in.green_in, pix_in.red_in};
    end
    if (go) begin
      last2 <= ctl1.last;
    end
    if (en3) begin
      last3  <= last2;
      alpha3 <= snap[4][31:24];
    end
    if (en4) begin
      pix_out.frame_last <= last3;
      pix_out.alpha_out  <= alpha3;
    end
  end

  w3f_line_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk(clk),
    .rst(rst),
    .rd_en(accept),
    .rd_addr(col[AW-1:0]),
    .go(go),
    .ctl(ctl1),
    .wr_addr(addr1),
    .px(px1),
    .snap(snap)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 9; i++) begin
        chan_px[k][i] = snap[i][k*8 +: 8];
      end
    end
  end

  w3f_chan_filter u_red (
    .clk(clk), .ld_a(en3), .ld_b(en4), .mode(filter_mode),
    .a(chan_px[0]), .res(pix_out.red_out)
  );

  w3f_chan_filter u_green (
    .clk(clk), .ld_a(en3), .ld_b(en4), .mode(filter_mode),
    .a(chan_px[1]), .res(pix_out.green_out)
  );

  w3f_chan_filter u_blue (
    .clk(clk), .ld_a(en3), .ld_b(en4), .mode(filter_mode),
    .a(chan_px[2]), .res(pix_out.blue_out)
  );

  assign pix_out.valid = out_v;

endmodule

// ===== sv/w3f_checker.sv =====
// Port-level checks for the window filter engine, bound to the top level.
module w3f_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] out_payload
);

  // A result waiting for the consumer stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The waiting result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_payload))
    else $error("result changed while stalled");

  // With the output empty, no stage can be blocked, so input must be taken.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused with an empty output");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind window_3x3_filter_engine w3f_checker u_w3f_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(pix_in.valid),
  .in_ready(pix_in.ready),
  .out_valid(pix_out.valid),
  .out_ready(pix_out.ready),
  .out_payload({pix_out.frame_last, pix_out.alpha_out, pix_out.blue_out,
                pix_out.green_out, pix_out.red_out})
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the 3x3 window filter engine with a pixel-accurate predictor.
module testbench;
  import w3f_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_result_t;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        cfg_en;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  int          errors;
  int          cycles;
  int          items_sent;
  bit          in_idle_on;
  bit          out_idle_on;

  w3f_pix_in_if  pix_in();
  w3f_pix_out_if pix_out();

  window_3x3_filter_engine dut (
    .clk(clk),
    .rst(rst),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_in(pix_in),
    .pix_out(pix_out)
  );

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Predicts filtered pixels from the accepted item stream and checks the output.
  class filter_scoreboard;
    logic [2:0]    mode;
    logic [11:0]   width_reg;
    logic [12:0]   height_reg;
    bit [31:0]     upper[W3F_MAX_WIDTH];
    bit [31:0]     middle[W3F_MAX_WIDTH];
    bit [31:0]     win[9];
    int unsigned   col;
    int unsigned   row;
    bit            draining;
    pixel_result_t expected_q[$];

    function new();
      mode = MODE_AVG;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (win[i]) win[i] = 0;
      foreach (upper[i]) begin
        upper[i] = 0;
        middle[i] = 0;
      end
      col = 0;
      row = 0;
      draining = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 2) return 2;
      if (width_reg > W3F_MAX_WIDTH) return W3F_MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg < 2) return 2;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(height_reg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [12:0] val);
      case (idx)
        REG_MODE:   mode = val[2:0];
        REG_WIDTH:  width_reg = val[11:0];
        REG_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function int clamp_byte(input int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    function int abs_diff(input int a, input int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // a[row*3+col], row 0 is the upper row and col 0 the left column.
    function int filter_channel(input int a[9]);
      int s[9];
      int sum, t, b, l, r, v, j;
      sum = 0;
      for (int i = 0; i < 9; i++) sum += a[i];
      case (mode)
        MODE_AVG: return sum / 9;
        MODE_MEDIAN: begin
          for (int i = 0; i < 9; i++) begin
            v = a[i];
            j = i;
            while (j > 0 && s[j-1] > v) begin
              s[j] = s[j-1];
              j--;
            end
            s[j] = v;
          end
          return s[4];
        end
        MODE_ROBERTS: return clamp_byte(abs_diff(a[4], a[2]) + abs_diff(a[5], a[1]));
        MODE_PREWITT: begin
          t = a[0] + a[1] + a[2];
          b = a[6] + a[7] + a[8];
          r = a[2] + a[5] + a[8];
          l = a[0] + a[3] + a[6];
          return clamp_byte(abs_diff(t, b) + abs_diff(r, l));
        end
        MODE_SOBEL: begin
          t = a[0] + 2 * a[1] + a[2];
          b = a[6] + 2 * a[7] + a[8];
          r = a[2] + 2 * a[5] + a[8];
          l = a[0] + 2 * a[3] + a[6];
          return clamp_byte(abs_diff(t, b) + abs_diff(r, l));
        end
        MODE_SHARPEN: return clamp_byte(10 * a[4] - sum);
        default: return a[4];
      endcase
    endfunction

    function void shift_column(input bit [31:0] top, input bit [31:0] mid,
                               input bit [31:0] bot);
      bit [31:0] c3[3];
      c3[0] = top;
      c3[1] = mid;
      c3[2] = bot;
      for (int r = 0; r < 3; r++) begin
        win[r*3] = win[r*3+1];
        win[r*3+1] = win[r*3+2];
        win[r*3+2] = c3[r];
      end
    endfunction

    // Columns cl, cm, cr of the window act as left, center and right.
    function void predict_pixel(input int cl, input int cm, input int cr, input bit last);
      int sel[3];
      int a[9];
      int ch[3];
      pixel_result_t res;
      sel[0] = cl;
      sel[1] = cm;
      sel[2] = cr;
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++)
          for (int j = 0; j < 3; j++)
            a[r*3+j] = (win[r*3+sel[j]] >> (8 * k)) & 255;
        ch[k] = filter_channel(a);
      end
      res.red = 8'(ch[0]);
      res.green = 8'(ch[1]);
      res.blue = 8'(ch[2]);
      res.alpha = win[3+cm][31:24];
      res.last = last;
      expected_q.push_back(res);
    endfunction

    function void take_item(input logic cmd, input bit [31:0] px);
      int unsigned w, h, c, r;
      bit ok;
      bit [31:0] up, md;
      w = eff_width();
      h = eff_height();
      c = col;
      r = row;
      ok = c < W3F_MAX_WIDTH;
      if (!draining) begin
        if (cmd == CMD_FLUSH) return;
        if (c == 0 && r >= 2) predict_pixel(1, 2, 2, 0);
        up = ok ? upper[c] : 0;
        md = ok ? middle[c] : 0;
        if (ok) begin
          upper[c] = md;
          middle[c] = px;
        end
        shift_column((r >= 2) ? up : md, md, px);
        if (c >= 1 && r >= 1) predict_pixel(c == 1 ? 1 : 0, 1, 2, 0);
        c++;
        if (c >= w) begin
          c = 0;
          r++;
          if (r >= h) begin
            r = 0;
            draining = 1;
          end
        end
        col = c;
        row = r;
        return;
      end
      // Drain: pixels act as flush items and replicate the bottom edge.
      if (c >= w) begin
        predict_pixel(1, 2, 2, 1);
        col = 0;
        row = 0;
        draining = 0;
        return;
      end
      if (c == 0) predict_pixel(1, 2, 2, 0);
      up = ok ? upper[c] : 0;
      md = ok ? middle[c] : 0;
      shift_column(up, md, md);
      if (c >= 1) predict_pixel(c == 1 ? 1 : 0, 1, 2, 0);
      col = c + 1;
    endfunction

    task check_result(input pixel_result_t got);
      pixel_result_t exp_px;
      if (expected_q.size() == 0) begin
        report("result with no expected pixel");
        return;
      end
      exp_px = expected_q.pop_front();
      if (got.red !== exp_px.red)
        report($sformatf("red_out %0d, expected %0d", got.red, exp_px.red));
      if (got.green !== exp_px.green)
        report($sformatf("green_out %0d, expected %0d", got.green, exp_px.green));
      if (got.blue !== exp_px.blue)
        report($sformatf("blue_out %0d, expected %0d", got.blue, exp_px.blue));
      if (got.alpha !== exp_px.alpha)
        report($sformatf("alpha_out %0d, expected %0d", got.alpha, exp_px.alpha));
      if (got.last !== exp_px.last)
        report($sformatf("frame_last %0b, expected %0b", got.last, exp_px.last));
    endtask
  endclass

  filter_scoreboard sb;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    pix_out.ready <= out_idle_on ? ($urandom_range(99) >= 25) : 1'b1;
  end

  always @(posedge clk) begin
    pixel_result_t got;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got.red = pix_out.red_out;
      got.green = pix_out.green_out;
      got.blue = pix_out.blue_out;
      got.alpha = pix_out.alpha_out;
      got.last = pix_out.frame_last;
      sb.check_result(got);
    end
  end

  task automatic send_item(input logic cmd, input bit [31:0] px);
    while (in_idle_on && $urandom_range(99) < 25) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.command <= cmd;
    pix_in.red_in <= px[7:0];
    pix_in.green_in <= px[15:8];
    pix_in.blue_in <= px[23:16];
    pix_in.alpha_in <= px[31:24];
    do @(posedge clk); while (!pix_in.ready);
    sb.take_item(cmd, px);
  endtask

  // Stops the sender until every expected pixel has left the block.
  task automatic hold_until_drained(input int extra);
    pix_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    hold_until_drained(8);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [2:0] mode, input logic [11:0] w,
                           input logic [12:0] h);
    write_reg(REG_MODE, {10'd0, mode});
    write_reg(REG_WIDTH, {1'b0, w});
    write_reg(REG_HEIGHT, h);
  endtask

  // One whole frame of random pixels followed by the drain items.
  task automatic run_frame(input bit noise, input bit pause_mid);
    int unsigned w, h;
    w = sb.eff_width();
    h = sb.eff_height();
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(99) < 5) send_item(CMD_FLUSH, $urandom);
      if (pause_mid && i == (w * h) / 2) hold_until_drained(1);
      send_item(CMD_PIXEL, $urandom);
      items_sent++;
    end
    for (int i = 0; i <= w; i++) begin
      send_item((noise && $urandom_range(3) == 0) ? CMD_PIXEL : CMD_FLUSH, $urandom);
      items_sent++;
    end
  endtask

  initial begin
    bit [31:0] corner[4];
    clk = 1'b0;
    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.command = CMD_PIXEL;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.alpha_in = '0;
    pix_out.ready = 1'b0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    in_idle_on = 1;
    out_idle_on = 1;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme pixel values on tiny frames, a flush inside a frame,
    // a pixel during the drain and an unused mode.
    corner[0] = 32'h0000_0000;
    corner[1] = 32'hFFFF_FFFF;
    corner[2] = 32'hFF00_FF00;
    corner[3] = 32'h00FF_00FF;
    configure(MODE_SHARPEN, 12'd2, 13'd2);
    for (int i = 0; i < 4; i++) send_item(CMD_PIXEL, corner[i]);
    send_item(CMD_FLUSH, '0);
    send_item(CMD_PIXEL, 32'hFFFF_FFFF);
    send_item(CMD_FLUSH, '0);
    configure(MODE_MEDIAN, 12'd3, 13'd2);
    for (int i = 0; i < 6; i++) begin
      if (i == 3) send_item(CMD_FLUSH, 32'hFFFF_FFFF);
      send_item(CMD_PIXEL, corner[(i * 3) % 4]);
    end
    for (int i = 0; i < 4; i++) send_item(CMD_FLUSH, '0);
    write_reg(REG_MODE, 13'd6);
    write_reg(REG_WIDTH, 13'd2);
    for (int i = 0; i < 4; i++) send_item(CMD_PIXEL, corner[3 - i]);
    for (int i = 0; i < 3; i++) send_item(CMD_FLUSH, '0);

    // Random frames: every mode, small sizes, clamped geometry now and then.
    while (items_sent < 560) begin
      configure(3'($urandom_range(7)),
                12'(($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 9)),
                13'(($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 6)));
      run_frame(1, items_sent == 0);
    end

    // A longer frame with no idling on either side.
    in_idle_on = 0;
    out_idle_on = 0;
    configure(MODE_SOBEL, 12'd32, 13'd3);
    run_frame(0, 0);
    in_idle_on = 1;
    out_idle_on = 1;

    hold_until_drained(20);
    if (sb.pending() != 0) report("expected pixels never arrived");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== window_3x3_filter_engine.f =====
sv/w3f_pkg.sv
sv/w3f_pix_in_if.sv
sv/w3f_pix_out_if.sv
sv/w3f_line_window.sv
sv/w3f_chan_filter.sv
sv/window_3x3_filter_engine.sv
sv/w3f_checker.sv
dv/testbench.sv
